### hw/rtl/sgmnr_pkg.sv
package sgmnr_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int COORD_W = 32;
  localparam int VALUE_W = 32;
  localparam int DIST_W  = 16;
  localparam int POS_W   = DIST_W + 3;
  localparam int KEY_W   = DIST_W + POS_W;
  localparam int OPC_W   = 2;

  localparam logic [OPC_W-1:0] OPC_READ    = 2'd0;
  localparam logic [OPC_W-1:0] OPC_WRITE   = 2'd1;
  localparam logic [OPC_W-1:0] OPC_NEAREST = 2'd2;

  typedef enum logic [2:0] {
    CMD_READ,
    CMD_SET,
    CMD_ERASE,
    CMD_NEAREST,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [COORD_W-1:0]   x;
    logic [COORD_W-1:0]   z;
    logic [VALUE_W-1:0]   value;
    logic [DIST_W-1:0]    maxd;
  } cmd_t;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic               table_full;
  } res_t;

endpackage

### hw/rtl/sgmnr_ram.sv
module sgmnr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/sgmnr_front.sv
module sgmnr_front import sgmnr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [OPC_W-1:0]   opcode,
  input  logic [COORD_W-1:0] x_coord,
  input  logic [COORD_W-1:0] z_coord,
  input  logic [VALUE_W-1:0] write_value,
  input  logic [DIST_W-1:0]  max_distance,
  output logic               cmd_valid,
  output cmd_t               cmd,
  input  logic               cmd_take
);

  cmd_t       q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  cmd_t       cls;
  logic       wr_en;
  logic       rd_en;

  // Decode the opcode into the operation the back end carries out.
  always_comb begin
    cls.x     = x_coord;
    cls.z     = z_coord;
    cls.value = write_value;
    cls.maxd  = max_distance;
    case (opcode)
      OPC_READ:    cls.kind = CMD_READ;
      OPC_WRITE:   cls.kind = (write_value == '0) ? CMD_ERASE : CMD_SET;
      OPC_NEAREST: cls.kind = CMD_NEAREST;
      default:     cls.kind = CMD_NOP;
    endcase
  end

  assign full      = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign wr_en     = push && !full;
  assign rd_en     = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (rd_en) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({wr_en, rd_en})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

### hw/rtl/sgmnr_back.sv
module sgmnr_back import sgmnr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_take,
  output logic res_valid,
  output res_t res,
  input  logic res_ready
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DRAIN  = 5'b00100,
    S_COMMIT = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

  state_t              state_r;
  state_t              state_nxt;
  cmd_t                cur_r;
  logic [IDX_W-1:0]    issue_idx_r;
  logic [ENTRIES-1:0]  valid_r;
  logic [ENTRIES-1:0]  valid_nxt;
  res_t                res_r;
  res_t                res_nxt;
  logic                start;
  logic                issue;

  // store ports
  logic                xz_we;
  logic                val_we;
  logic [IDX_W-1:0]    wr_idx;
  logic [COORD_W-1:0]  ex_rd;
  logic [COORD_W-1:0]  ez_rd;
  logic [VALUE_W-1:0]  ev_rd;

  // scan pipeline
  logic                s1_act_r;
  logic [IDX_W-1:0]    s1_idx_r;
  logic                s1_vld_r;

  logic                s2_act_r;
  logic [IDX_W-1:0]    s2_idx_r;
  logic                s2_vld_r;
  logic                s2_match_r;
  logic [COORD_W-1:0]  s2_dx_r;
  logic [COORD_W-1:0]  s2_dz_r;
  logic [VALUE_W-1:0]  s2_val_r;

  logic                s3_act_r;
  logic [IDX_W-1:0]    s3_idx_r;
  logic                s3_vld_r;
  logic                s3_match_r;
  logic [COORD_W-1:0]  s3_dx_r;
  logic [COORD_W-1:0]  s3_dz_r;
  logic [COORD_W-1:0]  s3_adx_r;
  logic [COORD_W-1:0]  s3_adz_r;
  logic [VALUE_W-1:0]  s3_val_r;

  logic                s4_act_r;
  logic [IDX_W-1:0]    s4_idx_r;
  logic                s4_vld_r;
  logic                s4_match_r;
  logic                s4_in_rng_r;
  logic [KEY_W-1:0]    s4_key_r;
  logic [VALUE_W-1:0]  s4_val_r;

  // running results of the scan
  logic                hit_r;
  logic [IDX_W-1:0]    hit_idx_r;
  logic [VALUE_W-1:0]  hit_val_r;
  logic                free_r;
  logic [IDX_W-1:0]    free_idx_r;
  logic                best_r;
  logic [KEY_W-1:0]    best_key_r;
  logic [VALUE_W-1:0]  best_val_r;

  // ring classification
  logic [COORD_W-1:0]  ring_r32;
  logic                in_rng;
  logic signed [19:0]  dxs;
  logic signed [19:0]  dzs;
  logic signed [19:0]  rs;
  logic signed [19:0]  pos_s;

  sgmnr_ram #(.WIDTH(COORD_W), .DEPTH(ENTRIES)) u_x_ram (
    .clk   (clk),
    .we    (xz_we),
    .waddr (wr_idx),
    .wdata (cur_r.x),
    .raddr (issue_idx_r),
    .rdata (ex_rd)
  );

  sgmnr_ram #(.WIDTH(COORD_W), .DEPTH(ENTRIES)) u_z_ram (
    .clk   (clk),
    .we    (xz_we),
    .waddr (wr_idx),
    .wdata (cur_r.z),
    .raddr (issue_idx_r),
    .rdata (ez_rd)
  );

  sgmnr_ram #(.WIDTH(VALUE_W), .DEPTH(ENTRIES)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (wr_idx),
    .wdata (cur_r.value),
    .raddr (issue_idx_r),
    .rdata (ev_rd)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    cmd_take  = 1'b0;
    issue     = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        cmd_take = cmd_valid;
        if (cmd_valid) begin
          state_nxt = (cmd.kind == CMD_NOP) ? S_COMMIT : S_SCAN;
        end
      end
      S_SCAN: begin
        issue = 1'b1;
        if (issue_idx_r == IDX_LAST) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!(s1_act_r || s2_act_r || s3_act_r || s4_act_r)) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign start = cmd_take;
  assign res   = res_r;

  // Ring radius and position along the ring walk. Position only matters
  // when the radius is below max_distance, so it fits narrow arithmetic.
  always_comb begin
    ring_r32 = (s3_adx_r > s3_adz_r) ? s3_adx_r : s3_adz_r;
    in_rng   = (ring_r32 != '0) && (ring_r32 < {{(COORD_W-DIST_W){1'b0}}, cur_r.maxd});
    dxs      = {{3{s3_dx_r[16]}}, s3_dx_r[16:0]};
    dzs      = {{3{s3_dz_r[16]}}, s3_dz_r[16:0]};
    rs       = {4'b0, ring_r32[DIST_W-1:0]};
    if ((dzs == -rs) && (dxs < rs)) begin
      pos_s = dxs + rs;
    end else if ((dxs == rs) && (dzs < rs)) begin
      pos_s = rs + rs + rs + dzs;
    end else if ((dzs == rs) && (dxs > -rs)) begin
      pos_s = (rs <<< 2) + rs - dxs;
    end else begin
      pos_s = (rs <<< 3) - rs - dzs;
    end
  end

  // Commit: build the answer and update the store.
  always_comb begin
    res_nxt   = '0;
    valid_nxt = valid_r;
    xz_we     = 1'b0;
    val_we    = 1'b0;
    wr_idx    = hit_idx_r;
    if (state_r == S_COMMIT) begin
      case (cur_r.kind)
        CMD_READ: begin
          res_nxt.read_value = hit_r ? hit_val_r : '0;
        end
        CMD_NEAREST: begin
          if (hit_r) begin
            res_nxt.read_value = hit_val_r;
          end else if (best_r) begin
            res_nxt.read_value = best_val_r;
          end
        end
        CMD_SET: begin
          if (hit_r) begin
            val_we = 1'b1;
          end else if (free_r) begin
            wr_idx             = free_idx_r;
            xz_we              = 1'b1;
            val_we             = 1'b1;
            valid_nxt[free_idx_r] = 1'b1;
          end else begin
            res_nxt.table_full = 1'b1;
          end
        end
        CMD_ERASE: begin
          if (hit_r) begin
            valid_nxt[hit_idx_r] = 1'b0;
          end
        end
        default: begin
          res_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      valid_r  <= '0;
      s1_act_r <= 1'b0;
      s2_act_r <= 1'b0;
      s3_act_r <= 1'b0;
      s4_act_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      valid_r  <= valid_nxt;
      s1_act_r <= issue;
      s2_act_r <= s1_act_r;
      s3_act_r <= s2_act_r;
      s4_act_r <= s3_act_r;
    end
  end

  // Payload and scan datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      cur_r       <= cmd;
      issue_idx_r <= '0;
    end else if (issue) begin
      issue_idx_r <= issue_idx_r + IDX_W'(1);
    end

    // stage 1: store read in flight, sample the valid bit alongside
    s1_idx_r <= issue_idx_r;
    s1_vld_r <= valid_r[issue_idx_r];

    // stage 2: wrapped offsets from the centre
    s2_idx_r   <= s1_idx_r;
    s2_vld_r   <= s1_vld_r;
    s2_match_r <= (ex_rd == cur_r.x) && (ez_rd == cur_r.z);
    s2_dx_r    <= ex_rd - cur_r.x;
    s2_dz_r    <= ez_rd - cur_r.z;
    s2_val_r   <= ev_rd;

    // stage 3: magnitudes
    s3_idx_r   <= s2_idx_r;
    s3_vld_r   <= s2_vld_r;
    s3_match_r <= s2_match_r;
    s3_dx_r    <= s2_dx_r;
    s3_dz_r    <= s2_dz_r;
    s3_adx_r   <= s2_dx_r[COORD_W-1] ? (~s2_dx_r + COORD_W'(1)) : s2_dx_r;
    s3_adz_r   <= s2_dz_r[COORD_W-1] ? (~s2_dz_r + COORD_W'(1)) : s2_dz_r;
    s3_val_r   <= s2_val_r;

    // stage 4: ring radius and walk position as one ordering key
    s4_idx_r    <= s3_idx_r;
    s4_vld_r    <= s3_vld_r;
    s4_match_r  <= s3_match_r;
    s4_in_rng_r <= in_rng;
    s4_key_r    <= {ring_r32[DIST_W-1:0], pos_s[POS_W-1:0]};
    s4_val_r    <= s3_val_r;

    if (state_r == S_COMMIT) begin
      res_r <= res_nxt;
    end

    if (start) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
      best_r <= 1'b0;
    end else if (s4_act_r) begin
      if (s4_vld_r && s4_match_r) begin
        hit_r     <= 1'b1;
        hit_idx_r <= s4_idx_r;
        hit_val_r <= s4_val_r;
      end
      // entries arrive in index order: keep the lowest free slot
      if (!s4_vld_r && !free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= s4_idx_r;
      end
      if (s4_vld_r && s4_in_rng_r && (!best_r || (s4_key_r < best_key_r))) begin
        best_r     <= 1'b1;
        best_key_r <= s4_key_r;
        best_val_r <= s4_val_r;
      end
    end
  end

endmodule

### hw/rtl/sgmnr_outq.sv
module sgmnr_outq import sgmnr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic res_valid,
  input  res_t res,
  output logic res_ready,
  output logic empty,
  input  logic pop,
  output res_t head
);

  res_t       q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       wr_en;
  logic       rd_en;

  assign res_ready = (cnt_r != 2'd2);
  assign empty     = (cnt_r == 2'd0);
  assign head      = q_r[rd_ptr_r];
  assign wr_en     = res_valid && res_ready;
  assign rd_en     = pop && !empty;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (rd_en) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({wr_en, rd_en})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

### hw/rtl/sparse_grid_map_nearest_ring_core.sv
// Sparse grid map: up to ENTRIES cells keyed by signed (x, z), each holding a
// nonzero 32-bit value. Opcode 0 reads a cell (0 when absent), opcode 1 writes
// it (value 0 erases; a new cell with no free slot is dropped and reported on
// table_full), opcode 2 returns the centre cell's value or else the first
// value met on the square rings of radius 1 .. max_distance-1, each ring
// walked from its low x / low z corner; opcode 3 answers 0. Both sides look
// like queues: push/full in, empty/pop out, each with two beats of buffering,
// so a new item is taken while a finished answer still waits. For every read,
// write and search the back end takes the command, then walks the whole
// table through one read port of the slot stores, one slot per cycle, drains
// the four-stage compare pipeline, updates the store and hands the answer
// over; it takes no new command until the answer is handed over. Opcode 3
// skips the walk and the drain. No clearing pass is needed after reset; the
// slot-in-use bits clear at once.
module sparse_grid_map_nearest_ring_core import sgmnr_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  output logic                      full,
  input  logic [OPC_W-1:0]          in_opcode,
  input  logic signed [COORD_W-1:0] in_x_coord,
  input  logic signed [COORD_W-1:0] in_z_coord,
  input  logic [VALUE_W-1:0]        in_write_value,
  input  logic [DIST_W-1:0]         in_max_distance,
  output logic                      empty,
  input  logic                      pop,
  output logic [VALUE_W-1:0]        out_read_value,
  output logic                      out_table_full
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;
  logic res_valid;
  res_t res;
  logic res_ready;
  res_t head;

  // Front: take input beats, decode the opcode, hold up to two commands.
  sgmnr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .opcode       (in_opcode),
    .x_coord      (in_x_coord),
    .z_coord      (in_z_coord),
    .write_value  (in_write_value),
    .max_distance (in_max_distance),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_take     (cmd_take)
  );

  // Back: walk the table, pick the answer, update the slot stores.
  sgmnr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // Hold finished answers until the consumer pops them.
  sgmnr_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .empty     (empty),
    .pop       (pop),
    .head      (head)
  );

  assign out_read_value = head.read_value;
  assign out_table_full = head.table_full;

endmodule
